FILE: rtl/rfgr_pkg.sv
`default_nettype none

package rfgr_pkg;

   // field widths
   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 7;
   localparam int STATE_W = 3;
   localparam int COUNT_W = 8;
   localparam int TICK_W  = 8;

   // buffer size default
   localparam int BUFFER_DEPTH_DEFAULT = 128;

   // command codes
   localparam logic [CMD_W-1:0] CMD_BYTE    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ARM     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

   // frame phase codes
   localparam logic [STATE_W-1:0] PH_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] PH_RECV = 3'd1;
   localparam logic [STATE_W-1:0] PH_GAP  = 3'd2;
   localparam logic [STATE_W-1:0] PH_DONE = 3'd3;
   localparam logic [STATE_W-1:0] PH_LATE = 3'd4;

   // csr register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_GAP  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_END = 1'd1;

   // csr reset values
   localparam logic [TICK_W-1:0] CHAR_GAP_RESET  = 8'd11;
   localparam logic [TICK_W-1:0] FRAME_END_RESET = 8'd22;
   localparam logic [TICK_W-1:0] SILENCE_MAX     = 8'd255;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [BYTE_W-1:0]  rx_byte;
      logic [INDEX_W-1:0] read_index;
   } req_payload_type;

   typedef struct packed {
      logic [STATE_W-1:0] frame_state;
      logic [COUNT_W-1:0] byte_count;
      logic [BYTE_W-1:0]  read_data;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: rtl/rtu_frame_gap_receiver.sv
`default_nettype none

// Frame receiver that delimits a serial reply by line silence. Each request beat carries
// one command (byte, tick, arm, buffer read, timer restart) and produces exactly one
// response beat with the phase and byte count after the update, plus the buffer byte for
// a read. A beat can be accepted every cycle while req_stall is low; the input register
// takes the beat, and the result register takes the updated state and drives the response
// beat once the response side is not stalled. The frame buffer is
// a memory with a registered read port; per-entry valid bits, cleared by reset, make
// unwritten entries read as zero, so no clearing pass is needed after reset.
module rtu_frame_gap_receiver #(
   parameter int BUFFER_DEPTH = rfgr_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  rfgr_pkg::req_payload_type     req_payload,
   // response channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output rfgr_pkg::rsp_payload_type           rsp_payload,
   // csr write port
   input  wire                                 csr_wr_en,
   input  wire  [rfgr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [rfgr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int WIDE_W = 9;

   // csr registers
   logic [rfgr_pkg::TICK_W-1:0] char_gap_ff;
   logic [rfgr_pkg::TICK_W-1:0] frame_end_ff;

   // input register
   logic                      s1_valid_ff;
   rfgr_pkg::req_payload_type s1_ff;

   // frame state
   logic [rfgr_pkg::STATE_W-1:0] phase_ff, phase_in;
   logic [rfgr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [rfgr_pkg::TICK_W-1:0]  silence_ff, silence_in;

   // buffer memory and entry valid bits
   logic [rfgr_pkg::BYTE_W-1:0] buf_mem [BUFFER_DEPTH];
   logic [BUFFER_DEPTH-1:0]     buf_vld_ff;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           rd_addr;
   logic                        rd_hit;

   // result register
   logic                         out_valid_ff;
   logic [rfgr_pkg::STATE_W-1:0] out_state_ff;
   logic [rfgr_pkg::COUNT_W-1:0] out_count_ff;
   logic [rfgr_pkg::BYTE_W-1:0]  out_data_ff;
   logic                         out_hit_ff;

   logic advance;
   logic step;

   // handshake
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         char_gap_ff  <= rfgr_pkg::CHAR_GAP_RESET;
         frame_end_ff <= rfgr_pkg::FRAME_END_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rfgr_pkg::CSR_CHAR_GAP:  char_gap_ff  <= csr_wdata;
            rfgr_pkg::CSR_FRAME_END: frame_end_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_ff <= req_payload;
      end
   end

   // read address and range check
   always_comb begin
      logic [WIDE_W-1:0] idx_wide;
      idx_wide = WIDE_W'(s1_ff.read_index);
      rd_addr  = idx_wide[ADDR_W-1:0];
      rd_hit   = (s1_ff.cmd == rfgr_pkg::CMD_READ)
               && (idx_wide < WIDE_W'(BUFFER_DEPTH))
               && buf_vld_ff[rd_addr];
   end

   // state update for one command
   always_comb begin
      logic [WIDE_W-1:0] pos;
      logic [rfgr_pkg::STATE_W-1:0] ph;
      logic [rfgr_pkg::TICK_W-1:0]  sil;
      pos        = '0;
      ph         = phase_ff;
      sil        = silence_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      unique case (s1_ff.cmd)
         rfgr_pkg::CMD_BYTE: begin
            sil = '0;
            pos = WIDE_W'(count_ff);
            if (ph == rfgr_pkg::PH_IDLE) begin
               pos = '0;
               ph  = rfgr_pkg::PH_RECV;
            end
            if (ph == rfgr_pkg::PH_RECV) begin
               // wrap to the start once the buffer is full
               if (pos >= WIDE_W'(BUFFER_DEPTH)) begin
                  pos = '0;
               end
               wr_en    = 1'b1;
               wr_addr  = pos[ADDR_W-1:0];
               count_in = rfgr_pkg::COUNT_W'(pos + WIDE_W'(1));
            end else if (ph == rfgr_pkg::PH_GAP) begin
               ph = rfgr_pkg::PH_LATE;
            end
         end
         rfgr_pkg::CMD_TICK: begin
            if (sil != rfgr_pkg::SILENCE_MAX) begin
               sil = sil + rfgr_pkg::TICK_W'(1);
            end
            // both thresholds may pass in the same tick
            if (sil > char_gap_ff && ph == rfgr_pkg::PH_RECV) begin
               ph = rfgr_pkg::PH_GAP;
            end
            if (sil > frame_end_ff && ph == rfgr_pkg::PH_GAP) begin
               ph = rfgr_pkg::PH_DONE;
            end
         end
         rfgr_pkg::CMD_ARM:     ph  = rfgr_pkg::PH_IDLE;
         rfgr_pkg::CMD_RESTART: sil = '0;
         default: ;
      endcase
      phase_in   = ph;
      silence_in = sil;
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rfgr_pkg::PH_IDLE;
         count_ff   <= '0;
         silence_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         silence_ff <= silence_in;
      end
   end

   // entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= '0;
      end else if (step && wr_en) begin
         buf_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // buffer memory with registered read
   always_ff @(posedge clock) begin
      if (step && wr_en) begin
         buf_mem[wr_addr] <= s1_ff.rx_byte;
      end
      if (advance) begin
         out_data_ff <= buf_mem[rd_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_state_ff <= phase_in;
         out_count_ff <= count_in;
         out_hit_ff   <= rd_hit;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_payload.frame_state = out_state_ff;
   assign rsp_payload.byte_count  = out_count_ff;
   assign rsp_payload.read_data   = out_hit_ff ? out_data_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/rfgr_checker.sv
`default_nettype none

module rfgr_checker #(
   parameter int BUFFER_DEPTH = rfgr_pkg::BUFFER_DEPTH_DEFAULT
) (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_stall,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire rfgr_pkg::rsp_payload_type     rsp_payload
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // no response beat right after reset
   a_rsp_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // requests only back up when the result register is full and stalled
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with room in the pipeline");

   // a receiving frame holds at least one byte unless the count wrapped
   a_recv_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_state == rfgr_pkg::PH_RECV && BUFFER_DEPTH < 256
      |-> rsp_payload.byte_count != '0)
      else $error("receiving with empty byte count");

endmodule

bind rtu_frame_gap_receiver rfgr_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_rfgr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
